// ===== hw/rtl/kvs_pkg.sv =====
package kvs_pkg;

   localparam int ENTRIES   = 16;
   localparam int KEY_BYTES = 8;
   localparam int KEY_W     = 64;
   localparam int VAL_W     = 32;

   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [KEY_W-1:0]        lookup_key;
      logic signed [VAL_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic used;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   // Broadcast controls for the whole row of cells.
   typedef struct packed {
      logic shift_down;
      logic shift_up;
      logic clear_all;
   } tbl_ctl_type;

   // Search token handed from one cell to the next.
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [VAL_W-1:0] value;
   } scan_type;

   // A key is a string: it ends at the first zero byte or after KEY_BYTES bytes.
   function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      logic             stop;
      r    = '0;
      stop = 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (k[8*i +: 8] == 8'd0) begin
            stop = 1'b1;
         end
         if (!stop) begin
            r[8*i +: 8] = k[8*i +: 8];
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/kvs_cell.sv =====
module kvs_cell
   import kvs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  tbl_ctl_type      ctl,
   input  logic             scan_start,
   input  logic [KEY_W-1:0] search_key,
   input  entry_type        prev_entry,
   input  entry_type        next_entry,
   output entry_type        entry,
   input  scan_type         scan_in,
   output scan_type         scan_out
);

   logic             used_ff, used_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             mark_ff, mark_in;
   scan_type         scan_ff, scan_in_next;
   logic             match;

   assign match = used_ff && (key_ff == search_key);

   always_comb begin
      used_in  = used_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.clear_all) begin
         used_in = 1'b0;
      end else if (ctl.shift_down) begin
         used_in  = prev_entry.used;
         key_in   = prev_entry.key;
         value_in = prev_entry.value;
      end else if (ctl.shift_up && mark_ff) begin
         // This cell sits at or below the deleted entry: close the gap.
         used_in  = next_entry.used;
         key_in   = next_entry.key;
         value_in = next_entry.value;
      end
   end

   always_comb begin
      scan_in_next.valid = scan_in.valid;
      scan_in_next.found = scan_in.found || match;
      if (scan_in.found) begin
         scan_in_next.value = scan_in.value;
      end else if (match) begin
         scan_in_next.value = value_ff;
      end else begin
         scan_in_next.value = '0;
      end
   end

   always_comb begin
      mark_in = mark_ff;
      if (scan_in.valid) begin
         mark_in = scan_in.found || match;
      end else if (scan_start) begin
         mark_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= 1'b0;
         mark_ff       <= 1'b0;
         scan_ff.valid <= 1'b0;
      end else begin
         used_ff       <= used_in;
         mark_ff       <= mark_in;
         scan_ff.valid <= scan_in_next.valid;
      end
      key_ff        <= key_in;
      value_ff      <= value_in;
      scan_ff.found <= scan_in_next.found;
      scan_ff.value <= scan_in_next.value;
   end

   assign entry.used  = used_ff;
   assign entry.key   = key_ff;
   assign entry.value = value_ff;
   assign scan_out    = scan_ff;

endmodule

// ===== hw/rtl/kvs_ctrl.sv =====
module kvs_ctrl
   import kvs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp,
   input  logic             full,
   input  scan_type         scan_done,
   output tbl_ctl_type      ctl,
   output entry_type        new_entry,
   output logic [KEY_W-1:0] search_key,
   output logic             scan_start
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic             state_ff, state_in;
   logic             start_ff, start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             spare_valid_ff, spare_valid_in;
   rsp_type          spare_ff, spare_in;
   logic             res_valid;
   rsp_type          res;
   logic [1:0]       op_ff;
   logic [KEY_W-1:0] key_ff;
   logic             accept;
   logic             rsp_free;
   logic             finish;
   logic [KEY_W-1:0] key_norm;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // A new item is taken only while the spare register is empty, so the result
   // of the item in flight always has a place to land.
   assign req_stall = (state_ff != ST_IDLE) || spare_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == ST_SCAN) && scan_done.valid;
   assign key_norm  = norm_key(req.lookup_key);

   assign new_entry.used  = 1'b1;
   assign new_entry.key   = key_norm;
   assign new_entry.value = req.write_value;

   assign ctl.shift_down = accept && (req.opcode == OP_SET) && !full;
   assign ctl.clear_all  = accept && (req.opcode == OP_CLEAR);
   assign ctl.shift_up   = finish && (op_ff == OP_DELETE) && scan_done.found;

   assign search_key = key_ff;
   assign scan_start = start_ff;

   always_comb begin
      state_in = state_ff;
      start_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && ((req.opcode == OP_GET) || (req.opcode == OP_DELETE))) begin
               state_in = ST_SCAN;
               start_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (scan_done.valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      if (accept) begin
         unique case (req.opcode) inside
            OP_SET: begin
               res_valid      = 1'b1;
               res.status     = full ? STATUS_FULL : STATUS_OK;
               res.read_value = '0;
            end
            OP_CLEAR: begin
               res_valid      = 1'b1;
               res.status     = STATUS_OK;
               res.read_value = '0;
            end
            OP_GET, OP_DELETE: begin
               res_valid = 1'b0;
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end else if (finish) begin
         res_valid = 1'b1;
         if (op_ff == OP_GET) begin
            res.status     = scan_done.found ? STATUS_OK : STATUS_NOT_FOUND;
            res.read_value = scan_done.value;
         end else begin
            res.status     = STATUS_OK;
            res.read_value = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      spare_valid_in = spare_valid_ff;
      spare_in       = spare_ff;
      if (rsp_free) begin
         if (spare_valid_ff) begin
            rsp_valid_in   = 1'b1;
            rsp_in         = spare_ff;
            spare_valid_in = 1'b0;
         end else if (res_valid) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
         end
      end
      // A fresh result only meets an empty spare register.
      if (res_valid && !rsp_free) begin
         spare_valid_in = 1'b1;
         spare_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_ff       <= start_in;
         rsp_valid_ff   <= rsp_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      rsp_ff   <= rsp_in;
      spare_ff <= spare_in;
      if (accept) begin
         op_ff  <= req.opcode;
         key_ff <= key_norm;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hw/rtl/key_value_store.sv =====
// Newest-first key/value table built as a row of ENTRIES cells, cell 0 holding
// the newest entry. A set or a clear item is taken without a search and its
// result goes straight to the result registers. A get or a delete item launches
// a search token that walks down the row one cell per clock and collects the
// newest match; no new item is taken until the token has left the last cell.
// A delete then shifts the older entries up by one. Keys end at their first
// zero byte. One finished result may wait in the output register while the
// next item is taken; the result of that item is held in a spare register,
// and the input stalls until the spare register has moved on to the output.
module key_value_store
   import kvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   tbl_ctl_type      ctl;
   entry_type        new_entry;
   entry_type        blank_entry;
   logic [KEY_W-1:0] search_key;
   logic             scan_start;
   entry_type        entry_w [ENTRIES];
   scan_type         scan_w  [ENTRIES+1];

   assign blank_entry.used  = 1'b0;
   assign blank_entry.key   = '0;
   assign blank_entry.value = '0;

   assign scan_w[0].valid = scan_start;
   assign scan_w[0].found = 1'b0;
   assign scan_w[0].value = '0;

   kvs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp),
      .full       (entry_w[ENTRIES-1].used),
      .scan_done  (scan_w[ENTRIES]),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .search_key (search_key),
      .scan_start (scan_start)
   );

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;

      if (g == 0) begin : g_head
         assign prev_e = new_entry;
      end else begin : g_body
         assign prev_e = entry_w[g-1];
      end

      if (g == ENTRIES-1) begin : g_tail
         assign next_e = blank_entry;
      end else begin : g_link
         assign next_e = entry_w[g+1];
      end

      kvs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .scan_start (scan_start),
         .search_key (search_key),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .entry      (entry_w[g]),
         .scan_in    (scan_w[g]),
         .scan_out   (scan_w[g+1])
      );
   end

endmodule

// ===== tb/sv/kvs_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the key/value table, keeps its own copy of the table
// and checks every result item against the expectation for the oldest operation.
module kvs_checker
   import kvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp,
   output int      err_count,
   output int      pending
);

   logic [KEY_W-1:0] tab_key [ENTRIES];
   logic [VAL_W-1:0] tab_val [ENTRIES];
   int               tab_fill;
   rsp_type          answer_q [$];
   int               rsp_seen;

   // The stored key is the string up to its first zero byte.
   function automatic logic [KEY_W-1:0] string_key(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] k;
      int               n;
      k = '0;
      n = 0;
      while (n < KEY_BYTES && raw[8*n +: 8] != 8'h00) begin
         k[8*n +: 8] = raw[8*n +: 8];
         n++;
      end
      return k;
   endfunction

   function automatic int newest_slot(input logic [KEY_W-1:0] k);
      for (int i = 0; i < tab_fill; i++) begin
         if (tab_key[i] == k) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Applies one operation to the table copy and returns the answer it earns.
   function automatic rsp_type table_answer(input req_type item);
      rsp_type          result;
      logic [KEY_W-1:0] k;
      int               hit;
      k               = string_key(item.lookup_key);
      hit             = newest_slot(k);
      result          = '0;
      result.status   = STATUS_OK;
      case (item.opcode)
         OP_SET: begin
            if (tab_fill >= ENTRIES) begin
               result.status = STATUS_FULL;
            end else begin
               for (int i = tab_fill; i > 0; i--) begin
                  tab_key[i] = tab_key[i-1];
                  tab_val[i] = tab_val[i-1];
               end
               tab_key[0] = k;
               tab_val[0] = item.write_value;
               tab_fill++;
            end
         end
         OP_GET: begin
            if (hit < 0) begin
               result.status = STATUS_NOT_FOUND;
            end else begin
               result.read_value = tab_val[hit];
            end
         end
         OP_DELETE: begin
            // Only the newest match goes; an older duplicate shows again.
            if (hit >= 0) begin
               for (int i = hit; i < tab_fill - 1; i++) begin
                  tab_key[i] = tab_key[i+1];
                  tab_val[i] = tab_val[i+1];
               end
               tab_fill--;
            end
         end
         default: begin
            tab_fill = 0;
         end
      endcase
      return result;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] result %0d: %s is %0h, expected %0h", $time, rsp_seen, what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         tab_fill = 0;
         answer_q.delete();
         rsp_seen = 0;
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (answer_q.size() == 0) begin
               report_mismatch("unexpected item, status", 32'(rsp.status), 32'(STATUS_OK));
            end else begin
               want = answer_q.pop_front();
               if (rsp.status !== want.status) begin
                  report_mismatch("status", 32'(rsp.status), 32'(want.status));
               end
               if (rsp.read_value !== want.read_value) begin
                  report_mismatch("read_value", rsp.read_value, want.read_value);
               end
            end
         end
         if (req_valid && !req_stall) begin
            answer_q.push_back(table_answer(req));
         end
         pending <= answer_q.size();
      end
   end

endmodule

// ===== tb/sv/tb_key_value_store.sv =====
`timescale 1ns / 100ps

module tb_key_value_store;
   import kvs_pkg::*;

   localparam int RANDOM_ITEMS = 1850;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
   localparam int POOL_SIZE    = 12;
   localparam int MAX_IDLE     = 17;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [KEY_W-1:0] KEY_A = 64'h0000_0000_0041_4243;
   localparam logic [KEY_W-1:0] KEY_B = 64'h0000_0000_0000_7A79;
   localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;
   int      err_count;
   int      pending;
   int      cycle_count = 0;
   int      items_sent  = 0;
   bit      send_calm   = 1'b0;

   logic [KEY_W-1:0] key_base [POOL_SIZE];
   int               key_len  [POOL_SIZE];

   key_value_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   kvs_checker kvs_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .err_count (err_count),
      .pending   (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic req_type make_req(input logic [1:0] op, input logic [KEY_W-1:0] k,
                                        input logic [VAL_W-1:0] v);
      req_type item;
      item.opcode      = op;
      item.lookup_key  = k;
      item.write_value = v;
      return item;
   endfunction

   // Same string as the pool entry, sometimes with random bytes after the terminating zero.
   function automatic logic [KEY_W-1:0] pool_key(input int idx);
      logic [KEY_W-1:0] k;
      k = key_base[idx];
      if (key_len[idx] < KEY_BYTES - 1 && $urandom_range(0, 1) == 1) begin
         for (int b = key_len[idx] + 1; b < KEY_BYTES; b++) begin
            k[8*b +: 8] = 8'($urandom_range(0, 255));
         end
      end
      return k;
   endfunction

   function automatic logic [VAL_W-1:0] any_value();
      case ($urandom_range(0, 19))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
      @(negedge clock);
   endtask

   // Result side: random stalls, calm stretches, and two long hold-offs that
   // let the block back up into its input.
   initial begin : result_sink
      int  taken;
      int  hold;
      bit  calm;
      taken = 0;
      calm  = 1'b0;
      @(negedge clock);
      forever begin
         if (taken % 64 == 0) begin
            calm = ($urandom_range(0, 2) == 0);
         end
         hold = calm ? 0 : $urandom_range(0, MAX_IDLE);
         if (taken == 500 || taken == 1300) begin
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) begin
            @(posedge clock);
         end
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int          scen;
      int          block_len;
      int          pick;
      logic [1:0]  op;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_len[i]  = $urandom_range(0, KEY_BYTES);
         key_base[i] = '0;
         for (int b = 0; b < key_len[i]; b++) begin
            key_base[i][8*b +: 8] = 8'($urandom_range(1, 255));
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: clear, delete and get all have nothing to touch.
      send_item(make_req(OP_CLEAR, KEY_A, '0));
      send_item(make_req(OP_DELETE, KEY_A, '0));
      send_item(make_req(OP_GET, KEY_A, '0));
      // Duplicates: deleting the newest one uncovers the older one.
      send_item(make_req(OP_SET, KEY_A, 32'd1));
      send_item(make_req(OP_SET, KEY_A, 32'd2));
      send_item(make_req(OP_GET, KEY_A, '0));
      send_item(make_req(OP_DELETE, KEY_A, '0));
      send_item(make_req(OP_GET, KEY_A, '0));
      send_item(make_req(OP_DELETE, KEY_B, '0));
      send_item(make_req(OP_GET, KEY_B, '0));
      // Bytes past the first zero byte are ignored on set, get and delete.
      send_item(make_req(OP_SET, 64'hDEAD_BEEF_0000_3132, VAL_MIN));
      send_item(make_req(OP_GET, 64'h1234_5678_9A00_3132, '0));
      send_item(make_req(OP_SET, 64'h0, VAL_MAX));
      send_item(make_req(OP_GET, 64'hFFFF_FFFF_FFFF_FF00, '0));
      send_item(make_req(OP_SET, '1, '1));
      send_item(make_req(OP_GET, '1, '0));
      send_item(make_req(OP_DELETE, 64'h5555_0000_0000_3132, '0));
      send_item(make_req(OP_GET, 64'h0000_0000_0000_3132, '0));
      send_item(make_req(OP_CLEAR, '1, '1));
      send_item(make_req(OP_GET, '1, '0));

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         scen      = $urandom_range(0, 9);
         send_calm = ($urandom_range(0, 2) == 0);
         if (scen < 3) begin
            // A run of sets that can fill the table and overflow it.
            block_len = $urandom_range(ENTRIES - 4, ENTRIES + 4);
            repeat (block_len) begin
               send_item(make_req(OP_SET, pool_key($urandom_range(0, POOL_SIZE - 1)),
                                  any_value()));
            end
         end else if (scen < 9) begin
            block_len = $urandom_range(10, 40);
            repeat (block_len) begin
               pick = $urandom_range(0, 99);
               if (pick < 40) begin
                  op = OP_SET;
               end else if (pick < 75) begin
                  op = OP_GET;
               end else if (pick < 97) begin
                  op = OP_DELETE;
               end else begin
                  op = OP_CLEAR;
               end
               send_item(make_req(op, pool_key($urandom_range(0, POOL_SIZE - 1)),
                                  any_value()));
            end
         end else begin
            block_len = $urandom_range(4, 12);
            repeat (block_len) begin
               op = 2'($urandom_range(0, 3));
               send_item(make_req(op, {$urandom, $urandom}, $urandom));
            end
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
